FILE: src/pfe_pkg.sv
// Shared types, constants and state codes for the prime field exponent unit.
package pfe_pkg;

    localparam int FE_W    = 256;
    localparam int LIMB_W  = 64;
    localparam int WORD_W  = 32;
    localparam int EXP_TOP_BIT = 252;

    localparam logic [FE_W-1:0] PRIME = {
        64'h62d7f37f9815e5fc, 64'ha7ecc14ec3fa83c7,
        64'hffffffffffffffff, 64'hffffffffffffffff};

    // (p-3)/4
    localparam logic [FE_W-1:0] EXPO = {
        64'h18B5FCDFE605797F, 64'h29FB3053B0FEA0F1,
        64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF};

    typedef enum logic [1:0] {
        ACT_INV  = 2'd0,
        ACT_SQRT = 2'd1,
        ACT_TEST = 2'd2,
        ACT_NEG  = 2'd3
    } pfe_action_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [LIMB_W-1:0] elem_limb0;
        logic [LIMB_W-1:0] elem_limb1;
        logic [LIMB_W-1:0] elem_limb2;
        logic [LIMB_W-1:0] elem_limb3;
    } pfe_in_t;

    typedef struct packed {
        logic [LIMB_W-1:0] res_limb0;
        logic [LIMB_W-1:0] res_limb1;
        logic [LIMB_W-1:0] res_limb2;
        logic [LIMB_W-1:0] res_limb3;
        logic              is_residue;
    } pfe_out_t;

    typedef enum logic [2:0] {
        SRC_A   = 3'd0,
        SRC_ACC = 3'd1,
        SRC_SQ  = 3'd2,
        SRC_TAB = 3'd3,
        SRC_ONE = 3'd4
    } pfe_src_t;

    typedef enum logic [1:0] {
        DST_ACC = 2'd0,
        DST_SQ  = 2'd1,
        DST_TAB = 2'd2
    } pfe_dst_t;

    typedef enum logic [4:0] {
        C_IDLE, C_RED1, C_RED2, C_NEG, C_INIT, C_TAB, C_SCAN, C_LOADW, C_LOAD,
        C_WIN, C_POST2, C_POST3, C_POST4, C_MPREP, C_MSTART, C_MWAIT, C_FIN
    } pfe_state_t;

    typedef enum logic [2:0] {
        MM_IDLE, MM_MUL, MM_MFOLD, MM_RED, MM_RFOLD, MM_FINAL, MM_DONE
    } pfe_mm_state_t;

    // pending Montgomery product: operands, destination, state to resume
    typedef struct packed {
        pfe_src_t   src_a;
        pfe_src_t   src_b;
        pfe_dst_t   dst;
        pfe_state_t ret;
    } pfe_call_t;

    typedef struct packed {
        logic     load_in;
        logic     reduce;
        logic     negate;
        logic     tab_init;
        logic     load_acc;
        logic     mul_start;
        pfe_src_t src_a;
        pfe_src_t src_b;
        pfe_dst_t dst;
        logic     out_load;
        logic     out_test;
    } pfe_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic out_free;
    } pfe_status_t;

endpackage

FILE: src/prime_field_exponent_unit.sv
// Top level of the prime field exponent unit.
// Inverse, square root and square test raise the operand to (p-3)/4 with a
// sliding window over a table of POWER_TABLE_DEPTH odd powers, every product
// going through one word-serial Montgomery multiplier (32x32 bits a cycle).
// With the default window of 5 bits that is roughly 320 products per item;
// negation needs no product: it reduces, negates and loads the output.
// One item is processed at a time; the next one is taken once the previous
// result is in the output register.
module prime_field_exponent_unit import pfe_pkg::*; #(
    parameter int WINDOW_BITS       = 5,
    parameter int POWER_TABLE_DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pfe_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfe_out_t m_data
);

    localparam int AW = (POWER_TABLE_DEPTH > 1) ? $clog2(POWER_TABLE_DEPTH) : 1;

    pfe_cmd_t      cmd;
    pfe_status_t   status;
    logic [AW-1:0] tab_raddr, tab_waddr;

    pfe_ctrl #(
        .WBITS (WINDOW_BITS),
        .DEPTH (POWER_TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_data.action),
        .status    (status),
        .cmd       (cmd),
        .tab_raddr (tab_raddr),
        .tab_waddr (tab_waddr)
    );

    pfe_dp #(
        .DEPTH (POWER_TABLE_DEPTH),
        .AW    (AW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .tab_raddr (tab_raddr),
        .tab_waddr (tab_waddr),
        .s_data    (s_data),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: src/pfe_mont.sv
// Word-serial Montgomery multiplier, 32-bit words, one 32x32 product per cycle.
module pfe_mont import pfe_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [FE_W-1:0] op_a,
    input  logic [FE_W-1:0] op_b,
    output logic            done,
    output logic [FE_W-1:0] res
);

    pfe_mm_state_t state_reg, state_next;

    logic [2:0]              j_reg, i_reg;
    logic [WORD_W-1:0]       carry_reg, m_reg, t8_reg;
    logic                    t9_reg;
    logic [FE_W-1:0]         a_reg, b_reg, res_reg;
    logic [7:0][WORD_W-1:0]  t_reg;

    logic [WORD_W-1:0]   mx, my, a_w, p_w, t_j;
    logic [2*WORD_W-1:0] sum;
    logic [WORD_W:0]     fold;
    logic [FE_W:0]       tfull, diff;

    always_comb begin
        a_w  = a_reg[{j_reg, 5'b0} +: WORD_W];
        p_w  = PRIME[{j_reg, 5'b0} +: WORD_W];
        t_j  = t_reg[j_reg];
        if (state_reg == MM_MUL) begin
            mx = a_w;
            my = b_reg[WORD_W-1:0];
        end else begin
            // first reduction word: m equals t[0] since -1/p is 1 mod 2^32
            mx = (j_reg == 3'd0) ? t_reg[0] : m_reg;
            my = p_w;
        end
        sum   = mx * my + {32'b0, t_j} + {32'b0, carry_reg};
        fold  = {1'b0, t8_reg} + {1'b0, carry_reg};
        tfull = {t8_reg[0], t_reg};
        diff  = tfull - {1'b0, PRIME};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MM_IDLE:  if (start) state_next = MM_MUL;
            MM_MUL:   if (j_reg == 3'd7) state_next = MM_MFOLD;
            MM_MFOLD: state_next = MM_RED;
            MM_RED:   if (j_reg == 3'd7) state_next = MM_RFOLD;
            MM_RFOLD: state_next = (i_reg == 3'd7) ? MM_FINAL : MM_MUL;
            MM_FINAL: state_next = MM_DONE;
            MM_DONE:  state_next = MM_IDLE;
            default:  state_next = MM_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == MM_DONE);
        res  = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MM_IDLE: begin
                a_reg     <= op_a;
                b_reg     <= op_b;
                t_reg     <= '0;
                t8_reg    <= '0;
                t9_reg    <= 1'b0;
                carry_reg <= '0;
                j_reg     <= '0;
                i_reg     <= '0;
            end
            MM_MUL: begin
                t_reg[j_reg] <= sum[WORD_W-1:0];
                carry_reg    <= sum[2*WORD_W-1:WORD_W];
                j_reg        <= j_reg + 3'd1;
            end
            MM_MFOLD: begin
                t8_reg    <= fold[WORD_W-1:0];
                t9_reg    <= fold[WORD_W];
                carry_reg <= '0;
            end
            MM_RED: begin
                if (j_reg == 3'd0) begin
                    m_reg <= t_reg[0];
                end else begin
                    t_reg[j_reg - 3'd1] <= sum[WORD_W-1:0];
                end
                carry_reg <= sum[2*WORD_W-1:WORD_W];
                j_reg     <= j_reg + 3'd1;
            end
            MM_RFOLD: begin
                t_reg[7]  <= fold[WORD_W-1:0];
                t8_reg    <= WORD_W'(t9_reg) + WORD_W'(fold[WORD_W]);
                t9_reg    <= 1'b0;
                carry_reg <= '0;
                b_reg     <= b_reg >> WORD_W;
                i_reg     <= i_reg + 3'd1;
            end
            MM_FINAL: begin
                res_reg <= (tfull >= {1'b0, PRIME}) ? diff[FE_W-1:0] : tfull[FE_W-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/pfe_dp.sv
// Datapath: operand and accumulator registers, odd-power table, multiplier, output register.
module pfe_dp import pfe_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfe_cmd_t          cmd,
    input  logic [AW-1:0]     tab_raddr,
    input  logic [AW-1:0]     tab_waddr,
    input  pfe_in_t           s_data,
    output pfe_status_t       status,
    output logic              m_valid,
    input  logic              m_ready,
    output pfe_out_t          m_data
);

    logic [FE_W-1:0] a_reg, acc_reg, sq_reg, tab_rd_reg;
    logic [FE_W-1:0] tab_mem [DEPTH];
    pfe_out_t        out_reg;
    logic            m_valid_reg;

    logic [FE_W-1:0] op_a, op_b, mul_res;
    logic            mul_done;

    always_comb begin
        case (cmd.src_a)
            SRC_A:   op_a = a_reg;
            SRC_ACC: op_a = acc_reg;
            SRC_SQ:  op_a = sq_reg;
            SRC_TAB: op_a = tab_rd_reg;
            SRC_ONE: op_a = FE_W'(1);
            default: op_a = acc_reg;
        endcase
        case (cmd.src_b)
            SRC_A:   op_b = a_reg;
            SRC_ACC: op_b = acc_reg;
            SRC_SQ:  op_b = sq_reg;
            SRC_TAB: op_b = tab_rd_reg;
            SRC_ONE: op_b = FE_W'(1);
            default: op_b = acc_reg;
        endcase
    end

    pfe_mont u_mont (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .res     (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= {s_data.elem_limb3, s_data.elem_limb2,
                      s_data.elem_limb1, s_data.elem_limb0};
        end else if (cmd.reduce && (a_reg >= PRIME)) begin
            a_reg <= a_reg - PRIME;
        end

        if (cmd.negate) begin
            acc_reg <= (a_reg == '0) ? '0 : PRIME - a_reg;
        end else if (cmd.load_acc) begin
            acc_reg <= tab_rd_reg;
        end else if (mul_done && cmd.dst == DST_ACC) begin
            acc_reg <= mul_res;
        end

        if (mul_done && cmd.dst == DST_SQ) begin
            sq_reg <= mul_res;
        end

        if (cmd.tab_init) begin
            tab_mem[tab_waddr] <= a_reg;
        end else if (mul_done && cmd.dst == DST_TAB) begin
            tab_mem[tab_waddr] <= mul_res;
        end
        tab_rd_reg <= tab_mem[tab_raddr];

        if (cmd.out_load) begin
            if (cmd.out_test) begin
                out_reg.res_limb0  <= '0;
                out_reg.res_limb1  <= '0;
                out_reg.res_limb2  <= '0;
                out_reg.res_limb3  <= '0;
                out_reg.is_residue <= (acc_reg == FE_W'(1));
            end else begin
                out_reg.res_limb0  <= acc_reg[63:0];
                out_reg.res_limb1  <= acc_reg[127:64];
                out_reg.res_limb2  <= acc_reg[191:128];
                out_reg.res_limb3  <= acc_reg[255:192];
                out_reg.is_residue <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.mul_done = mul_done;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: src/pfe_ctrl.sv
// Controller: reduction, negation, table build, sliding-window exponent scan and final steps.
module pfe_ctrl import pfe_pkg::*; #(
    parameter int WBITS = 5,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_action,
    input  pfe_status_t   status,
    output pfe_cmd_t      cmd,
    output logic [AW-1:0] tab_raddr,
    output logic [AW-1:0] tab_waddr
);

    localparam int KW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(WBITS + 1);
    localparam logic [FE_W+WBITS-1:0] EXT = {EXPO, WBITS'(0)};

    pfe_state_t  state_reg, state_next;
    pfe_action_t action_reg, action_next;
    pfe_call_t   call_reg, call_next;
    logic [KW-1:0] k_reg, k_next;
    logic signed [9:0] i_reg, i_next;
    logic        started_reg, started_next;
    logic [LW-1:0] wcnt_reg, wcnt_next;
    logic [AW-1:0] raddr_reg, raddr_next, waddr_reg, waddr_next;

    logic [8:0]       idx;
    logic [WBITS-1:0] win, val, v;
    logic [LW-1:0]    wlen;

    // longest window ending in a set bit whose odd power is in the table
    always_comb begin
        idx  = i_reg[8:0] + 9'd1;
        win  = EXT[idx +: WBITS];
        val  = WBITS'(1);
        wlen = LW'(1);
        v    = '0;
        for (int len = 2; len <= WBITS; len++) begin
            if ((int'(i_reg[8:0]) >= len - 1) && win[WBITS-len]) begin
                v = win >> (WBITS - len);
                if (int'(v >> 1) < DEPTH) begin
                    val  = v;
                    wlen = LW'(len);
                end
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        action_next  = action_reg;
        call_next    = call_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        started_next = started_reg;
        wcnt_next    = wcnt_reg;
        raddr_next   = raddr_reg;
        waddr_next   = waddr_reg;
        case (state_reg)
            C_IDLE: if (s_valid) begin
                action_next = pfe_action_t'(s_action);
                state_next  = C_RED1;
            end
            C_RED1: state_next = C_RED2;
            C_RED2: begin
                waddr_next = '0;
                state_next = (action_reg == ACT_NEG) ? C_NEG : C_INIT;
            end
            C_NEG: state_next = C_FIN;
            C_INIT: begin
                k_next     = KW'(1);
                call_next  = '{SRC_A, SRC_A, DST_SQ, C_TAB};
                state_next = C_MPREP;
            end
            C_TAB: begin
                if (k_reg == KW'(DEPTH)) begin
                    i_next       = 10'(EXP_TOP_BIT);
                    started_next = 1'b0;
                    state_next   = C_SCAN;
                end else begin
                    raddr_next = AW'(k_reg - KW'(1));
                    waddr_next = AW'(k_reg);
                    k_next     = k_reg + KW'(1);
                    call_next  = '{SRC_TAB, SRC_SQ, DST_TAB, C_TAB};
                    state_next = C_MPREP;
                end
            end
            C_SCAN: begin
                if (i_reg[9]) begin
                    state_next = C_MPREP;
                    case (action_reg)
                        ACT_SQRT: call_next = '{SRC_ACC, SRC_A, DST_ACC, C_FIN};
                        ACT_INV:  call_next = '{SRC_ACC, SRC_ACC, DST_ACC, C_POST2};
                        default:  call_next = '{SRC_ACC, SRC_ACC, DST_ACC, C_POST3};
                    endcase
                end else if (!win[WBITS-1]) begin
                    i_next = i_reg - 10'sd1;
                    if (started_reg) begin
                        call_next  = '{SRC_ACC, SRC_ACC, DST_ACC, C_SCAN};
                        state_next = C_MPREP;
                    end
                end else begin
                    raddr_next = AW'(val >> 1);
                    i_next     = i_reg - 10'(wlen);
                    if (!started_reg) begin
                        started_next = 1'b1;
                        state_next   = C_LOADW;
                    end else begin
                        wcnt_next  = wlen;
                        state_next = C_WIN;
                    end
                end
            end
            C_LOADW: state_next = C_LOAD;
            C_LOAD:  state_next = C_SCAN;
            C_WIN: begin
                state_next = C_MPREP;
                if (wcnt_reg != '0) begin
                    wcnt_next = wcnt_reg - LW'(1);
                    call_next = '{SRC_ACC, SRC_ACC, DST_ACC, C_WIN};
                end else begin
                    call_next = '{SRC_ACC, SRC_TAB, DST_ACC, C_SCAN};
                end
            end
            C_POST2: begin
                call_next  = '{SRC_ACC, SRC_ACC, DST_ACC, C_POST3};
                state_next = C_MPREP;
            end
            C_POST3: begin
                call_next  = '{SRC_ACC, SRC_A, DST_ACC,
                              (action_reg == ACT_TEST) ? C_POST4 : C_FIN};
                state_next = C_MPREP;
            end
            C_POST4: begin
                call_next  = '{SRC_ACC, SRC_ONE, DST_ACC, C_FIN};
                state_next = C_MPREP;
            end
            C_MPREP:  state_next = C_MSTART;
            C_MSTART: state_next = C_MWAIT;
            C_MWAIT:  if (status.mul_done) state_next = call_reg.ret;
            C_FIN:    if (status.out_free) state_next = C_IDLE;
            default:  state_next = C_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.src_a = call_reg.src_a;
        cmd.src_b = call_reg.src_b;
        cmd.dst   = call_reg.dst;
        s_ready   = 1'b0;
        case (state_reg)
            C_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            C_RED1, C_RED2: cmd.reduce = 1'b1;
            C_NEG:    cmd.negate    = 1'b1;
            C_INIT:   cmd.tab_init  = 1'b1;
            C_LOAD:   cmd.load_acc  = 1'b1;
            C_MSTART: cmd.mul_start = 1'b1;
            C_FIN: begin
                cmd.out_load = status.out_free;
                cmd.out_test = (action_reg == ACT_TEST);
            end
            default: begin
            end
        endcase
    end

    assign tab_raddr = raddr_reg;
    assign tab_waddr = waddr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        call_reg   <= call_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        wcnt_reg   <= wcnt_next;
        raddr_reg  <= raddr_next;
        waddr_reg  <= waddr_next;
    end

endmodule

FILE: src/pfe_checker.sv
// Port-level checks for the prime field exponent unit, bound to the top level.
module pfe_checker import pfe_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pfe_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input pfe_out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_test_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_residue |-> m_data.res_limb0 == '0 &&
        m_data.res_limb1 == '0 && m_data.res_limb2 == '0 && m_data.res_limb3 == '0)
        else $error("square test result with nonzero limbs");

endmodule

bind prime_field_exponent_unit pfe_checker u_pfe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
